// File: hw/rtl/mvt_pkg.sv
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int CFG_WIDTH   = 64;
    localparam int COEF_FRAC   = 12;
    localparam int DATA_FRAC   = 16;
    localparam int DOT_LATENCY = 4;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_FULL  = 2'd0;
    localparam t_cmd CMD_POINT = 2'd1;
    localparam t_cmd CMD_DIR   = 2'd2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ROW_ZERO  = 2'd0;
    localparam t_reg_idx REG_ROW_ONE   = 2'd1;
    localparam t_reg_idx REG_ROW_TWO   = 2'd2;
    localparam t_reg_idx REG_ROW_THREE = 2'd3;

    typedef logic [CFG_WIDTH-1:0] t_row;

    // identity matrix
    localparam t_row ROW_RESET [NUM_ROWS] = '{
        64'h0000_0000_0000_1000,
        64'h0000_0000_1000_0000,
        64'h0000_1000_0000_0000,
        64'h1000_0000_0000_0000
    };

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

// File: hw/rtl/mvt_cfg.sv
`timescale 1ns / 1ps

module mvt_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  mvt_pkg::t_reg_idx i_cfg_index,
    input  mvt_pkg::t_row     i_cfg_data,
    output mvt_pkg::t_row     o_rows [mvt_pkg::NUM_ROWS]
);
    import mvt_pkg::*;

    t_row r_row [NUM_ROWS];
    t_row n_row [NUM_ROWS];

    always_comb begin
        n_row = r_row;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_ZERO:  n_row[0] = i_cfg_data;
                REG_ROW_ONE:   n_row[1] = i_cfg_data;
                REG_ROW_TWO:   n_row[2] = i_cfg_data;
                REG_ROW_THREE: n_row[3] = i_cfg_data;
                default:       n_row = r_row;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= ROW_RESET;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_rows = r_row;

endmodule

// File: hw/rtl/mvt_dot.sv
`timescale 1ns / 1ps

module mvt_dot #(
    parameter int COEF_WIDTH = 16,
    parameter int DATA_WIDTH = 32,
    parameter int VEC_WIDTH  = 34
) (
    input  logic                        i_clk,
    input  mvt_pkg::t_row               i_row,
    input  logic signed [VEC_WIDTH-1:0] i_vec [mvt_pkg::NUM_COLS],
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                        o_sat
);
    import mvt_pkg::*;

    localparam int PAD_WIDTH = CFG_WIDTH + NUM_COLS * COEF_WIDTH;
    localparam int PROD_W    = COEF_WIDTH + VEC_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W + 1;
    localparam int OUT_W     = RND_W - COEF_FRAC;
    localparam int TOP_W     = OUT_W - DATA_WIDTH + 1;

    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [PAD_WIDTH-1:0]          w_row_ext;
    logic signed [COEF_WIDTH-1:0]  w_coef [NUM_COLS];
    logic signed [PROD_W-1:0]      r_prod [NUM_COLS];
    logic signed [SUM_W-1:0]       r_pair [2];
    logic signed [SUM_W-1:0]       r_total;
    logic signed [RND_W-1:0]       w_biased;
    logic signed [OUT_W-1:0]       w_rounded;
    logic [TOP_W-1:0]              w_top;
    logic                          w_over;
    logic signed [DATA_WIDTH-1:0]  n_result;
    logic signed [DATA_WIDTH-1:0]  r_result;
    logic                          r_sat;

    // lanes past the register top read as zero
    assign w_row_ext = {{(PAD_WIDTH-CFG_WIDTH){1'b0}}, i_row};

    for (genvar k = 0; k < NUM_COLS; k++) begin : g_col
        assign w_coef[k] = signed'(w_row_ext[k*COEF_WIDTH +: COEF_WIDTH]);

        always_ff @(posedge i_clk) begin
            r_prod[k] <= PROD_W'(w_coef[k] * i_vec[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair[0] <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]);
        r_pair[1] <= SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
        r_total   <= r_pair[0] + r_pair[1];
    end

    // round half up, then floor shift
    assign w_biased  = RND_W'(r_total) + HALF;
    assign w_rounded = OUT_W'(w_biased >>> COEF_FRAC);
    assign w_top     = w_rounded[OUT_W-1:DATA_WIDTH-1];
    assign w_over    = !((&w_top) || !(|w_top));

    always_comb begin
        if (!w_over) begin
            n_result = w_rounded[DATA_WIDTH-1:0];
        end else if (w_rounded[OUT_W-1]) begin
            n_result = MIN_VAL;
        end else begin
            n_result = MAX_VAL;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_sat    <= w_over;
    end

    assign o_result = r_result;
    assign o_sat    = r_sat;

endmodule

// File: hw/rtl/matrix_vector_transform_4x4_top.sv
// Homogeneous 4x4 matrix-vector transform. Each item on i_start is a vector
// (x, y, z, w) in signed Q16.16; the result is the product with the matrix
// held in four 64-bit row registers (four Q4.12 coefficients each, column 1
// in the low bits), rounded half up and saturated, with o_saturated flagging
// any clipped component. i_command selects the full vector, a point (w = 1.0)
// or a direction (w = 0). o_busy stays low: an item is taken every cycle and
// its result appears on o_valid after one input register, then four stages
// per row: multiply, pair add, final add, round and clip. The result is
// shown for one cycle only and the receiver cannot stall it. Row registers
// reset to the identity and must be written only while no items are in
// flight.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_top #(
    parameter int COEF_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  mvt_pkg::t_reg_idx            i_cfg_index,
    input  mvt_pkg::t_row                i_cfg_data,
    input  logic                         i_start,
    output logic                         o_busy,
    input  mvt_pkg::t_cmd                i_command,
    input  logic signed [DATA_WIDTH-1:0] i_vec_x,
    input  logic signed [DATA_WIDTH-1:0] i_vec_y,
    input  logic signed [DATA_WIDTH-1:0] i_vec_z,
    input  logic signed [DATA_WIDTH-1:0] i_vec_w,
    input  logic                         i_last_in,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_out_x,
    output logic signed [DATA_WIDTH-1:0] o_out_y,
    output logic signed [DATA_WIDTH-1:0] o_out_z,
    output logic signed [DATA_WIDTH-1:0] o_out_w,
    output logic                         o_saturated,
    output logic                         o_last_out
);
    import mvt_pkg::*;

    localparam int VEC_WIDTH = DATA_WIDTH + 2;
    localparam logic signed [VEC_WIDTH-1:0] W_ONE = VEC_WIDTH'(1) << DATA_FRAC;

    t_row                        w_rows [NUM_ROWS];
    logic signed [VEC_WIDTH-1:0] n_vec  [NUM_COLS];
    logic signed [VEC_WIDTH-1:0] r_vec  [NUM_COLS];
    t_ctl                        n_ctl;
    t_ctl                        r_ctl  [DOT_LATENCY+1];
    logic signed [DATA_WIDTH-1:0] w_res [NUM_ROWS];
    logic [NUM_ROWS-1:0]         w_sat;
    logic                        w_accept;

    mvt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rows      (w_rows)
    );

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_vec[0] = VEC_WIDTH'(i_vec_x);
        n_vec[1] = VEC_WIDTH'(i_vec_y);
        n_vec[2] = VEC_WIDTH'(i_vec_z);
        case (i_command)
            CMD_POINT: n_vec[3] = W_ONE;
            CMD_DIR:   n_vec[3] = '0;
            default:   n_vec[3] = VEC_WIDTH'(i_vec_w);
        endcase
        n_ctl.valid = w_accept;
        n_ctl.last  = i_last_in;
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DOT_LATENCY; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_ctl[0] <= n_ctl;
            for (int i = 1; i <= DOT_LATENCY; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        mvt_dot #(
            .COEF_WIDTH (COEF_WIDTH),
            .DATA_WIDTH (DATA_WIDTH),
            .VEC_WIDTH  (VEC_WIDTH)
        ) u_dot (
            .i_clk    (i_clk),
            .i_row    (w_rows[r]),
            .i_vec    (r_vec),
            .o_result (w_res[r]),
            .o_sat    (w_sat[r])
        );
    end

    assign o_valid     = r_ctl[DOT_LATENCY].valid;
    assign o_out_x     = w_res[0];
    assign o_out_y     = w_res[1];
    assign o_out_z     = w_res[2];
    assign o_out_w     = w_res[3];
    assign o_saturated = o_valid && (|w_sat);
    assign o_last_out  = o_valid && r_ctl[DOT_LATENCY].last;

endmodule

// File: hw/rtl/mvt_check.sv
`timescale 1ns / 1ps

module mvt_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic i_last_in,
    input logic o_valid,
    input logic o_saturated,
    input logic o_last_out
);
    logic w_acc;

    assign w_acc = i_start && !o_busy && i_rst_n;

    // every accepted item comes out on o_valid unless reset intervened
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc, 5) && $past(i_rst_n, 4) && $past(i_rst_n, 3)
            && $past(i_rst_n, 2) && $past(i_rst_n, 1) |-> o_valid)
        else $error("accepted item produced no result");

    // no result without a matching accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, 5))
        else $error("result without matching item");

    // last marker follows its item
    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_out == $past(i_last_in, 5)))
        else $error("last marker mismatch");

    // flags quiet between results
    a_flags_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (!o_last_out && !o_saturated))
        else $error("flag set without result");

endmodule

bind matrix_vector_transform_4x4_top mvt_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_last_in   (i_last_in),
    .o_valid     (o_valid),
    .o_saturated (o_saturated),
    .o_last_out  (o_last_out)
);
